// ===== rtl/core/hds_pkg.sv =====
// ----------------------------------------------------------------------------
// hds_pkg
// Shared types, constants and helpers for the 3D diffusion stencil.
// ----------------------------------------------------------------------------
package hds_pkg;

  localparam int unsigned MAX_I   = 256;
  localparam int unsigned MAX_J   = 256;
  localparam int unsigned MAX_K   = 1024;
  // cell history depth, holds two full planes at the largest extents
  localparam int unsigned HIST_AW = 17;
  localparam int unsigned Q_DEPTH = 8;
  localparam int unsigned Q_AW    = 3;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_COEF_X = 3'd0,
    REG_COEF_Y = 3'd1,
    REG_COEF_Z = 3'd2,
    REG_SIZE_I = 3'd3,
    REG_SIZE_J = 3'd4,
    REG_SIZE_K = 3'd5
  } reg_idx_t;

  // face flag positions, in emission order
  localparam int unsigned F_I0 = 0;
  localparam int unsigned F_I1 = 1;
  localparam int unsigned F_J0 = 2;
  localparam int unsigned F_J1 = 3;
  localparam int unsigned F_K0 = 4;
  localparam int unsigned F_K1 = 5;

  // stencil taps of one centre, captured at accept
  typedef struct packed {
    logic              vld;
    logic signed [31:0] c;
    logic signed [31:0] w;
    logic signed [31:0] e;
    logic signed [31:0] s;
    logic signed [31:0] n;
    logic signed [31:0] d;
    logic signed [31:0] u;
    logic [7:0]        ci;
    logic [7:0]        cj;
    logic [9:0]        ck;
    logic [5:0]        flags;
  } tap_t;

  // finished centre, queued for the back end
  typedef struct packed {
    logic              vld;
    logic signed [31:0] value;
    logic [7:0]        ci;
    logic [7:0]        cj;
    logic [9:0]        ck;
    logic [5:0]        flags;
  } res_t;

  function automatic logic [8:0] eff_ij(input logic [8:0] r, input logic [8:0] mx);
    logic [8:0] v;
    if (r < 9'd3) v = 9'd3;
    else if (r > mx) v = mx;
    else v = r;
    return v;
  endfunction

  function automatic logic [10:0] eff_k(input logic [10:0] r);
    logic [10:0] v;
    if (r < 11'd3) v = 11'd3;
    else if (r > 11'(MAX_K)) v = 11'(MAX_K);
    else v = r;
    return v;
  endfunction

endpackage

// ===== rtl/core/hds_hist.sv =====
// ----------------------------------------------------------------------------
// hds_hist
// Cell history memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module hds_hist import hds_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [HIST_AW-1:0] waddr,
  input  logic [31:0]        wdata,
  input  logic [HIST_AW-1:0] raddr0,
  input  logic [HIST_AW-1:0] raddr1,
  output logic [31:0]        rdata0,
  output logic [31:0]        rdata1
);

  logic [31:0] mem [2**HIST_AW];
  logic [31:0] rd0_r;
  logic [31:0] rd1_r;

  // read-before-write, both ports advance with each accepted cell
  always_ff @(posedge clk) begin
    if (en) begin
      mem[waddr] <= wdata;
      rd0_r      <= mem[raddr0];
      rd1_r      <= mem[raddr1];
    end
  end

  assign rdata0 = rd0_r;
  assign rdata1 = rd1_r;

endmodule

// ===== rtl/core/hds_front.sv =====
// ----------------------------------------------------------------------------
// hds_front
// Accepts cells, tracks raster position, keeps history, classifies centres.
// ----------------------------------------------------------------------------
module hds_front import hds_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        acc,
  input  logic [31:0] cell_in,
  input  logic        grid_start,
  input  logic [8:0]  si,
  input  logic [8:0]  sj,
  input  logic [10:0] sk,
  output tap_t        tap
);

  logic [7:0]         pos_i_r, pos_j_r;
  logic [9:0]         pos_k_r;
  logic [7:0]         pos_i_nxt, pos_j_nxt;
  logic [9:0]         pos_k_nxt;
  logic [HIST_AW-1:0] wptr_r;
  logic [7:0]         pi, pj;
  logic [9:0]         pk, ck;
  logic [16:0]        plane;
  logic [HIST_AW-1:0] a_wm1, a_ms, a_ps, a_2p;
  logic [31:0]        rd_w, rd_s, rd_n, rd_d;
  logic [31:0]        c_r, e_r;
  logic               inter;
  logic [5:0]         flags;
  tap_t               tap_r;

  assign plane = {8'd0, si} * {8'd0, sj};
  assign pi = grid_start ? 8'd0  : pos_i_r;
  assign pj = grid_start ? 8'd0  : pos_j_r;
  assign pk = grid_start ? 10'd0 : pos_k_r;
  assign ck = pk - 10'd1;

  // read addresses for the next cell's taps
  assign a_wm1 = wptr_r + 17'd2 - plane;
  assign a_ms  = wptr_r + 17'd1 - plane + 17'(si);
  assign a_ps  = wptr_r + 17'd1 - plane - 17'(si);
  assign a_2p  = wptr_r + 17'd1 - 17'({plane, 1'b0});

  hds_hist u_hist_a (
    .clk(clk), .en(acc), .waddr(wptr_r), .wdata(cell_in),
    .raddr0(a_wm1), .raddr1(a_ms), .rdata0(rd_w), .rdata1(rd_s)
  );

  hds_hist u_hist_b (
    .clk(clk), .en(acc), .waddr(wptr_r), .wdata(cell_in),
    .raddr0(a_ps), .raddr1(a_2p), .rdata0(rd_n), .rdata1(rd_d)
  );

  // centre classification
  always_comb begin
    inter = (pk >= 10'd2) && ({1'b0, pk} < sk) && (pi >= 8'd1) &&
            ({1'b0, pi} + 9'd2 <= si) && (pj >= 8'd1) && ({1'b0, pj} + 9'd2 <= sj);
    flags        = '0;
    flags[F_I0]  = (pi == 8'd1);
    flags[F_I1]  = ({1'b0, pi} == si - 9'd2);
    flags[F_J0]  = (pj == 8'd1);
    flags[F_J1]  = ({1'b0, pj} == sj - 9'd2);
    flags[F_K0]  = (ck == 10'd1);
    flags[F_K1]  = ({1'b0, ck} == sk - 11'd2);
  end

  // raster advance
  always_comb begin
    pos_i_nxt = pi + 8'd1;
    pos_j_nxt = pj;
    pos_k_nxt = pk;
    if ({1'b0, pi} + 9'd1 >= si) begin
      pos_i_nxt = '0;
      if ({1'b0, pj} + 9'd1 >= sj) begin
        pos_j_nxt = '0;
        pos_k_nxt = ({1'b0, pk} + 11'd1 >= sk) ? 10'd0 : pk + 10'd1;
      end else begin
        pos_j_nxt = pj + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_i_r   <= '0;
      pos_j_r   <= '0;
      pos_k_r   <= '0;
      wptr_r    <= '0;
      tap_r.vld <= 1'b0;
    end else begin
      tap_r.vld <= acc && inter;
      if (acc) begin
        pos_i_r <= pos_i_nxt;
        pos_j_r <= pos_j_nxt;
        pos_k_r <= pos_k_nxt;
        wptr_r  <= wptr_r + 17'd1;
        // tap capture; c and e trail the plane-1 read by one and two cells
        c_r         <= rd_w;
        e_r         <= c_r;
        tap_r.c     <= c_r;
        tap_r.e     <= e_r;
        tap_r.w     <= rd_w;
        tap_r.s     <= rd_s;
        tap_r.n     <= rd_n;
        tap_r.d     <= rd_d;
        tap_r.u     <= cell_in;
        tap_r.ci    <= pi;
        tap_r.cj    <= pj;
        tap_r.ck    <= ck;
        tap_r.flags <= flags;
      end
    end
  end

  assign tap = tap_r;

endmodule

// ===== rtl/core/hds_calc.sv =====
// ----------------------------------------------------------------------------
// hds_calc
// Laplacian, coefficient scaling, rounding and saturation pipeline.
// ----------------------------------------------------------------------------
module hds_calc import hds_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  tap_t        tap,
  input  logic [31:0] coef_x,
  input  logic [31:0] coef_y,
  input  logic [31:0] coef_z,
  output res_t        res,
  output logic [2:0]  busy
);

  typedef struct packed {
    logic [7:0] ci;
    logic [7:0] cj;
    logic [9:0] ck;
    logic [5:0] flags;
  } meta_t;

  logic               v2_r, v3_r, v4_r;
  meta_t              m2_r, m3_r, m4_r;
  logic signed [31:0] c2_r, c3_r, c4_r;
  logic signed [33:0] lap_r [3];
  logic signed [50:0] a_r [3];
  logic signed [50:0] b_r [3];
  logic signed [35:0] t_r [3];
  logic signed [33:0] lap_nxt [3];
  logic signed [35:0] t_nxt [3];
  logic [31:0]        coef [3];
  logic signed [37:0] sum;
  logic signed [31:0] sat;

  assign coef[0] = coef_x;
  assign coef[1] = coef_y;
  assign coef[2] = coef_z;

  always_comb begin
    lap_nxt[0] = 34'(tap.w) + 34'(tap.e) - (34'(tap.c) <<< 1);
    lap_nxt[1] = 34'(tap.s) + 34'(tap.n) - (34'(tap.c) <<< 1);
    lap_nxt[2] = 34'(tap.d) + 34'(tap.u) - (34'(tap.c) <<< 1);
  end

  // round half up of the two partial products
  always_comb begin
    for (int t = 0; t < 3; t++) begin
      t_nxt[t] = 36'((a_r[t] + 51'sd32768 + (b_r[t] >>> 16)) >>> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v2_r <= tap.vld;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    m2_r <= '{ci: tap.ci, cj: tap.cj, ck: tap.ck, flags: tap.flags};
    c2_r <= tap.c;
    m3_r <= m2_r;
    c3_r <= c2_r;
    m4_r <= m3_r;
    c4_r <= c3_r;
    for (int t = 0; t < 3; t++) begin
      lap_r[t] <= lap_nxt[t];
      a_r[t]   <= 51'(lap_r[t]) * 51'($signed({1'b0, coef[t][31:16]}));
      b_r[t]   <= 51'(lap_r[t]) * 51'($signed({1'b0, coef[t][15:0]}));
      t_r[t]   <= t_nxt[t];
    end
  end

  // final sum and clamp
  always_comb begin
    sum = 38'(c4_r) + 38'(t_r[0]) + 38'(t_r[1]) + 38'(t_r[2]);
    if (sum > 38'sh0_7FFF_FFFF) sat = 32'sh7FFF_FFFF;
    else if (sum < -38'sh0_8000_0000) sat = 32'sh8000_0000;
    else sat = sum[31:0];
  end

  assign res  = '{vld: v4_r, value: sat, ci: m4_r.ci, cj: m4_r.cj, ck: m4_r.ck,
                  flags: m4_r.flags};
  assign busy = 3'(tap.vld) + 3'(v2_r) + 3'(v3_r) + 3'(v4_r);

endmodule

// ===== rtl/core/hds_back.sv =====
// ----------------------------------------------------------------------------
// hds_back
// Result queue and expander into centre and mirror-face transactions.
// ----------------------------------------------------------------------------
module hds_back import hds_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  res_t          res,
  input  logic [8:0]    si,
  input  logic [8:0]    sj,
  input  logic [10:0]   sk,
  output logic [Q_AW:0] q_count,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [63:0]   out_data,
  output logic          out_last
);

  res_t            q_mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_r, rd_r;
  logic [Q_AW:0]   cnt_r;
  logic [1:0]      n_r;
  logic [5:0]      mask_r;
  logic            ov_r, ol_r;
  logic [7:0]      oi_r, oj_r;
  logic [9:0]      ok_r;
  logic [31:0]     oval_r;
  res_t            head;
  logic [5:0]      cur, low, rest;
  logic            load, last, pop;
  logic [7:0]      ei, ej;
  logic [9:0]      ek;

  assign head = q_mem[rd_r];
  assign cur  = (n_r == 2'd0) ? head.flags : mask_r;
  assign load = (cnt_r != '0) && (!ov_r || out_ready);
  assign pop  = load && last;

  // pick lowest pending face and its coordinates
  always_comb begin
    low = '0;
    for (int f = 5; f >= 0; f--) begin
      if (cur[f]) low = 6'(1 << f);
    end
    rest = cur & ~low;
    last = ((n_r == 2'd0) ? (cur == '0) : (rest == '0)) || (n_r == 2'd3);
    ei = head.ci;
    ej = head.cj;
    ek = head.ck;
    if (n_r != 2'd0) begin
      if (low[F_I0]) ei = '0;
      if (low[F_I1]) ei = 8'(si - 9'd1);
      if (low[F_J0]) ej = '0;
      if (low[F_J1]) ej = 8'(sj - 9'd1);
      if (low[F_K0]) ek = '0;
      if (low[F_K1]) ek = 10'(sk - 11'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (res.vld) q_mem[wr_r] <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
      n_r   <= '0;
      ov_r  <= 1'b0;
    end else begin
      if (res.vld) wr_r <= wr_r + 1'b1;
      if (pop) rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + (Q_AW+1)'(res.vld) - (Q_AW+1)'(pop);
      if (load) begin
        ov_r <= 1'b1;
        n_r  <= last ? 2'd0 : n_r + 2'd1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (load) begin
      mask_r <= (n_r == 2'd0) ? cur : rest;
      oi_r   <= ei;
      oj_r   <= ej;
      ok_r   <= ek;
      oval_r <= head.value;
      ol_r   <= last;
    end
  end

  assign q_count   = cnt_r;
  assign out_valid = ov_r;
  assign out_data  = {6'd0, oval_r, ok_r, oj_r, oi_r};
  assign out_last  = ol_r;

endmodule

// ===== rtl/core/heat_diffusion_stencil_3d.sv =====
// ----------------------------------------------------------------------------
// heat_diffusion_stencil_3d
// One explicit 7-point diffusion step over a raster-streamed 3D grid.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  in_*     in   tdata[31:0] cell_value, tuser[0] grid_start
//  out_*    out  tdata i/j/k/new_value, tlast last_of_run
//  cfg_*    in   register index, write data
//
// One cell is taken per clock while in_tready is high; each history memory
// serves one write and two reads per cell. A centre is registered into the
// result queue and yields one to four transactions, one a clock unless stalled.
// Reset is synchronous and clears control state only; history is not cleared.
// in_tready drops when the result queue plus pipeline would exceed 8 entries.
// ----------------------------------------------------------------------------
module heat_diffusion_stencil_3d import hds_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] cell_value
  input  logic [0:0]  in_tuser,   // [0] grid_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [7:0] i, [15:8] j, [25:16] k, [57:26] new_value
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_data
);

  logic [31:0]   coef_x_r, coef_y_r, coef_z_r;
  logic [8:0]    size_i_r, size_j_r;
  logic [10:0]   size_k_r;
  logic [8:0]    si, sj;
  logic [10:0]   sk;
  logic          acc;
  tap_t          tap;
  res_t          res;
  logic [2:0]    busy;
  logic [Q_AW:0] q_count;

  assign si  = eff_ij(size_i_r, 9'(MAX_I));
  assign sj  = eff_ij(size_j_r, 9'(MAX_J));
  assign sk  = eff_k(size_k_r);
  assign acc = in_tvalid && in_tready;
  assign in_tready = ({1'b0, q_count} + 5'(busy)) < 5'(Q_DEPTH);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_x_r <= '0;
      coef_y_r <= '0;
      coef_z_r <= '0;
      size_i_r <= 9'(MAX_I);
      size_j_r <= 9'(MAX_J);
      size_k_r <= 11'(MAX_K);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_COEF_X: coef_x_r <= cfg_data;
        REG_COEF_Y: coef_y_r <= cfg_data;
        REG_COEF_Z: coef_z_r <= cfg_data;
        REG_SIZE_I: size_i_r <= cfg_data[8:0];
        REG_SIZE_J: size_j_r <= cfg_data[8:0];
        REG_SIZE_K: size_k_r <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  hds_front u_front (
    .clk(clk), .rst_n(rst_n), .acc(acc), .cell_in(in_tdata),
    .grid_start(in_tuser[0]), .si(si), .sj(sj), .sk(sk), .tap(tap)
  );

  hds_calc u_calc (
    .clk(clk), .rst_n(rst_n), .tap(tap), .coef_x(coef_x_r),
    .coef_y(coef_y_r), .coef_z(coef_z_r), .res(res), .busy(busy)
  );

  hds_back u_back (
    .clk(clk), .rst_n(rst_n), .res(res), .si(si), .sj(sj), .sk(sk),
    .q_count(q_count), .out_valid(out_tvalid), .out_ready(out_tready),
    .out_data(out_tdata), .out_last(out_tlast)
  );

endmodule

// ===== rtl/core/hds_checker.sv =====
// ----------------------------------------------------------------------------
// hds_checker
// Port-level checks for the diffusion stencil.
// ----------------------------------------------------------------------------
module hds_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tlast
);

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // with nothing queued the input side is open
  a_rst_rdy: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

  // padding bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[63:58] == 6'd0))
    else $error("nonzero padding in result");

  // a stalled transaction holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

endmodule

bind heat_diffusion_stencil_3d hds_checker u_hds_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata), .out_tlast(out_tlast)
);
